>>> design/dqe_pkg.sv
// ----------------------------------------------------------------------------
// dqe_pkg
// Shared types, constants and helpers for the double-ended queue engine.
// ----------------------------------------------------------------------------
package dqe_pkg;

	// store geometry
	localparam int DEPTH = 1024;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;
	localparam int COUNT_W = 11;

	// command codes
	localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [2:0] CMD_POP_BACK   = 3'd3;
	localparam logic [2:0] CMD_CLEAR      = 3'd4;
	localparam logic [2:0] CMD_REVERSE    = 3'd5;
	localparam logic [2:0] CMD_SORT       = 3'd6;

	// status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// word reported for both ends of an empty queue
	localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

	typedef struct packed {
		logic [2:0]               cmd;
		logic signed [WORD_W-1:0] value;
	} cmd_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] back_value;
		logic [COUNT_W-1:0]       count;
		logic [1:0]               status;
	} res_item_t;

	// store port request from the sequencer
	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [WORD_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} ram_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_REV_CHK,
		S_REV_RI,
		S_REV_RJ,
		S_REV_WI,
		S_REV_WJ,
		S_SRT_CHK,
		S_SRT_RK,
		S_SRT_KEY,
		S_SRT_TEST,
		S_SRT_CMP,
		S_SRT_PUT,
		S_RD_F,
		S_RD_B,
		S_RD_W
	} seq_state_t;

	// physical slot of logical position pos, wrapping once around the store
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
			input logic [IDX_W-1:0] pos);
		logic [IDX_W:0] sum;
		sum = {1'b0, head} + {1'b0, pos};
		if (sum >= (IDX_W+1)'(DEPTH)) begin
			sum = sum - (IDX_W+1)'(DEPTH);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

>>> design/dqe_ram.sv
// ----------------------------------------------------------------------------
// dqe_ram
// Circular word store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dqe_ram (
	input  logic                      clk,
	input  dqe_pkg::ram_req_t         req,
	output logic [dqe_pkg::WORD_W-1:0] rdata
);

	logic [dqe_pkg::WORD_W-1:0] mem [dqe_pkg::DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[req.raddr];
	end

endmodule

>>> design/dqe_ctrl.sv
// ----------------------------------------------------------------------------
// dqe_ctrl
// Command sequencer: pointer update, reverse swap walk, insertion sort with
// one shared signed comparator, and end readout for the result.
// ----------------------------------------------------------------------------
module dqe_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_ready,
	input  dqe_pkg::cmd_item_t         cmd_item,
	output logic                       res_valid,
	input  logic                       res_ready,
	output dqe_pkg::res_item_t         res_item,
	output dqe_pkg::ram_req_t          ram_req,
	input  logic [dqe_pkg::WORD_W-1:0] ram_rdata
);

	dqe_pkg::seq_state_t state_q, state_d;

	logic [dqe_pkg::IDX_W-1:0]  head_q;
	logic [dqe_pkg::CNT_W-1:0]  count_q;
	logic [2:0]                 cmd_q;
	logic [dqe_pkg::WORD_W-1:0] value_q;
	logic [1:0]                 status_q;
	logic [dqe_pkg::CNT_W-1:0]  i_q, j_q;
	logic [dqe_pkg::WORD_W-1:0] key_q, a_q, front_q;

	logic                       is_full, is_empty, has_two;
	logic [dqe_pkg::CNT_W-1:0]  cnt_m1, j_m1;
	logic [dqe_pkg::IDX_W-1:0]  head_dec, head_inc, slot_i, slot_j, slot_jm1;
	logic [dqe_pkg::IDX_W-1:0]  slot_back, slot_tail;
	logic                       key_less;

	// occupancy and address helpers
	assign is_full   = (count_q == dqe_pkg::CNT_W'(dqe_pkg::DEPTH));
	assign is_empty  = (count_q == '0);
	assign has_two   = (count_q > dqe_pkg::CNT_W'(1));
	assign cnt_m1    = count_q - dqe_pkg::CNT_W'(1);
	assign j_m1      = j_q - dqe_pkg::CNT_W'(1);
	assign head_dec  = (head_q == '0) ? dqe_pkg::IDX_W'(dqe_pkg::DEPTH - 1)
		: head_q - dqe_pkg::IDX_W'(1);
	assign head_inc  = dqe_pkg::slot_of(head_q, dqe_pkg::IDX_W'(1));
	assign slot_i    = dqe_pkg::slot_of(head_q, i_q[dqe_pkg::IDX_W-1:0]);
	assign slot_j    = dqe_pkg::slot_of(head_q, j_q[dqe_pkg::IDX_W-1:0]);
	assign slot_jm1  = dqe_pkg::slot_of(head_q, j_m1[dqe_pkg::IDX_W-1:0]);
	assign slot_back = dqe_pkg::slot_of(head_q, cnt_m1[dqe_pkg::IDX_W-1:0]);
	assign slot_tail = dqe_pkg::slot_of(head_q, count_q[dqe_pkg::IDX_W-1:0]);

	// shared signed comparator for the sort walk
	assign key_less = ($signed(key_q) < $signed(ram_rdata));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dqe_pkg::S_IDLE: begin
				if (cmd_valid) state_d = dqe_pkg::S_EXEC;
			end
			dqe_pkg::S_EXEC: begin
				unique case (cmd_q)
					dqe_pkg::CMD_REVERSE:
						state_d = has_two ? dqe_pkg::S_REV_CHK : dqe_pkg::S_RD_F;
					dqe_pkg::CMD_SORT:
						state_d = has_two ? dqe_pkg::S_SRT_CHK : dqe_pkg::S_RD_F;
					default:
						state_d = dqe_pkg::S_RD_F;
				endcase
			end
			dqe_pkg::S_REV_CHK: begin
				state_d = (i_q < j_q) ? dqe_pkg::S_REV_RI : dqe_pkg::S_RD_F;
			end
			dqe_pkg::S_REV_RI:   state_d = dqe_pkg::S_REV_RJ;
			dqe_pkg::S_REV_RJ:   state_d = dqe_pkg::S_REV_WI;
			dqe_pkg::S_REV_WI:   state_d = dqe_pkg::S_REV_WJ;
			dqe_pkg::S_REV_WJ:   state_d = dqe_pkg::S_REV_CHK;
			dqe_pkg::S_SRT_CHK: begin
				state_d = (i_q < count_q) ? dqe_pkg::S_SRT_RK : dqe_pkg::S_RD_F;
			end
			dqe_pkg::S_SRT_RK:   state_d = dqe_pkg::S_SRT_KEY;
			dqe_pkg::S_SRT_KEY:  state_d = dqe_pkg::S_SRT_TEST;
			dqe_pkg::S_SRT_TEST: begin
				state_d = (j_q == '0) ? dqe_pkg::S_SRT_PUT : dqe_pkg::S_SRT_CMP;
			end
			dqe_pkg::S_SRT_CMP: begin
				state_d = key_less ? dqe_pkg::S_SRT_TEST : dqe_pkg::S_SRT_PUT;
			end
			dqe_pkg::S_SRT_PUT:  state_d = dqe_pkg::S_SRT_CHK;
			dqe_pkg::S_RD_F:     state_d = dqe_pkg::S_RD_B;
			dqe_pkg::S_RD_B:     state_d = dqe_pkg::S_RD_W;
			dqe_pkg::S_RD_W: begin
				if (res_ready) state_d = dqe_pkg::S_IDLE;
			end
			default:             state_d = dqe_pkg::S_IDLE;
		endcase
	end

	// outputs: store port, handshakes
	always_comb begin
		ram_req   = '0;
		cmd_ready = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			dqe_pkg::S_IDLE: cmd_ready = 1'b1;
			dqe_pkg::S_EXEC: begin
				if (cmd_q == dqe_pkg::CMD_PUSH_FRONT && !is_full) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = head_dec;
					ram_req.wdata = value_q;
				end else if (cmd_q == dqe_pkg::CMD_PUSH_BACK && !is_full) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = slot_tail;
					ram_req.wdata = value_q;
				end
			end
			dqe_pkg::S_REV_RI: ram_req.raddr = slot_i;
			dqe_pkg::S_REV_RJ: ram_req.raddr = slot_j;
			dqe_pkg::S_REV_WI: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = slot_i;
				ram_req.wdata = ram_rdata;
			end
			dqe_pkg::S_REV_WJ: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = slot_j;
				ram_req.wdata = a_q;
			end
			dqe_pkg::S_SRT_RK:   ram_req.raddr = slot_i;
			dqe_pkg::S_SRT_TEST: ram_req.raddr = slot_jm1;
			dqe_pkg::S_SRT_CMP: begin
				if (key_less) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = slot_j;
					ram_req.wdata = ram_rdata;
				end
			end
			dqe_pkg::S_SRT_PUT: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = slot_j;
				ram_req.wdata = key_q;
			end
			dqe_pkg::S_RD_F: ram_req.raddr = head_q;
			dqe_pkg::S_RD_B: ram_req.raddr = slot_back;
			// keep reading the back slot so the word stays on the read port
			dqe_pkg::S_RD_W: begin
				ram_req.raddr = slot_back;
				res_valid     = 1'b1;
			end
			default: begin
				ram_req = '0;
			end
		endcase
	end

	// result item
	always_comb begin
		res_item.front_value = is_empty ? dqe_pkg::EMPTY_WORD : front_q;
		res_item.back_value  = is_empty ? dqe_pkg::EMPTY_WORD : ram_rdata;
		res_item.count       = dqe_pkg::COUNT_W'(count_q);
		res_item.status      = status_q;
	end

	// state, head and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dqe_pkg::S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == dqe_pkg::S_EXEC) begin
				case (cmd_q)
					dqe_pkg::CMD_PUSH_FRONT: begin
						if (!is_full) begin
							head_q  <= head_dec;
							count_q <= count_q + dqe_pkg::CNT_W'(1);
						end
					end
					dqe_pkg::CMD_PUSH_BACK: begin
						if (!is_full) count_q <= count_q + dqe_pkg::CNT_W'(1);
					end
					dqe_pkg::CMD_POP_FRONT: begin
						if (!is_empty) begin
							head_q  <= head_inc;
							count_q <= cnt_m1;
						end
					end
					dqe_pkg::CMD_POP_BACK: begin
						if (!is_empty) count_q <= cnt_m1;
					end
					dqe_pkg::CMD_CLEAR: begin
						head_q  <= '0;
						count_q <= '0;
					end
					default: begin
						head_q <= head_q;
					end
				endcase
			end
		end
	end

	// working registers of the walks and the readout
	always_ff @(posedge clk) begin
		case (state_q)
			dqe_pkg::S_IDLE: begin
				if (cmd_valid) begin
					cmd_q   <= cmd_item.cmd;
					value_q <= cmd_item.value;
				end
			end
			dqe_pkg::S_EXEC: begin
				status_q <= dqe_pkg::ST_DONE;
				case (cmd_q)
					dqe_pkg::CMD_PUSH_FRONT, dqe_pkg::CMD_PUSH_BACK: begin
						if (is_full) status_q <= dqe_pkg::ST_FULL;
					end
					dqe_pkg::CMD_POP_FRONT, dqe_pkg::CMD_POP_BACK: begin
						if (is_empty) status_q <= dqe_pkg::ST_EMPTY;
					end
					dqe_pkg::CMD_REVERSE: begin
						i_q <= '0;
						j_q <= cnt_m1;
					end
					dqe_pkg::CMD_SORT: begin
						i_q <= dqe_pkg::CNT_W'(1);
					end
					default: begin
						status_q <= dqe_pkg::ST_DONE;
					end
				endcase
			end
			dqe_pkg::S_REV_RJ: a_q <= ram_rdata;
			dqe_pkg::S_REV_WJ: begin
				i_q <= i_q + dqe_pkg::CNT_W'(1);
				j_q <= j_m1;
			end
			dqe_pkg::S_SRT_RK:  j_q <= i_q;
			dqe_pkg::S_SRT_KEY: key_q <= ram_rdata;
			dqe_pkg::S_SRT_CMP: begin
				if (key_less) j_q <= j_m1;
			end
			dqe_pkg::S_SRT_PUT: i_q <= i_q + dqe_pkg::CNT_W'(1);
			dqe_pkg::S_RD_B:    front_q <= ram_rdata;
			default: begin
				a_q <= a_q;
			end
		endcase
	end

endmodule

>>> design/double_ended_queue_engine_top.sv
// ----------------------------------------------------------------------------
// double_ended_queue_engine_top
// Double-ended queue of signed words in a circular store, with push, pop,
// clear, reverse and sort commands and one result item per command.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  cmd     | in        | cmd_valid/cmd_ready  | cmd_item (cmd, value)
//  res     | out       | res_valid/res_ready  | res_item (front, back, count, status)
//
//  push, pop, clear and unused codes: execute, read front, read back, then hold
//  the result until it is taken; a new command is accepted only after that.
//  reverse: check, read i, read j, write i, write j per swapped pair; sort: check,
//  read, key, test per entry after the first, compare and test per shift, then put.
//  the result waits in an output register; a new command is taken meanwhile.
//  reset empties the queue; stored words are not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_engine_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  dqe_pkg::cmd_item_t cmd_item,
	output logic               res_valid,
	input  logic               res_ready,
	output dqe_pkg::res_item_t res_item
);

	dqe_pkg::ram_req_t          ram_req;
	logic [dqe_pkg::WORD_W-1:0] ram_rdata;
	logic                       seq_res_valid;
	logic                       seq_res_ready;
	dqe_pkg::res_item_t         seq_res_item;
	logic                       res_valid_q;
	dqe_pkg::res_item_t         res_item_q;

	dqe_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	dqe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_item  (cmd_item),
		.res_valid (seq_res_valid),
		.res_ready (seq_res_ready),
		.res_item  (seq_res_item),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	// output register frees when empty or being taken
	assign seq_res_ready = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (seq_res_ready) begin
			res_valid_q <= seq_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_res_ready && seq_res_valid) begin
			res_item_q <= seq_res_item;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

>>> bench/tb_double_ended_queue_engine_top.sv
// ----------------------------------------------------------------------------
// tb_double_ended_queue_engine_top
// Self-checking bench for the double-ended queue engine. A shadow copy of
// the queue predicts every result item; a short table of directed commands
// covers the empty, single-entry and extreme-value cases; random traffic
// with bursty stalls on both channels then exercises every command at small
// depths, with one long receiver hold-off and one full drain.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_engine_top;

	localparam logic [2:0] CMD_UNUSED = 3'd7;
	localparam logic signed [dqe_pkg::WORD_W-1:0] MAX_WORD = 32'sh7FFF_FFFF;
	localparam logic signed [dqe_pkg::WORD_W-1:0] MIN_WORD = 32'sh8000_0000;
	localparam logic signed [dqe_pkg::WORD_W-1:0] NO_END   = dqe_pkg::EMPTY_WORD;
	localparam int RESET_CYCLES   = 11;
	localparam int RANDOM_ITEMS   = 775;
	localparam int CALM_ITEMS     = 120;
	localparam int HOLD_AT_ITEM   = 100;
	localparam int DEPTH_CAP      = 60;
	localparam int RX_HOLD_CYCLES = 300;
	localparam int STALL_LIMIT    = 20000;
	localparam int TAIL_CYCLES    = 40;
	localparam int EXP_SLOTS      = 16;
	localparam int ROW_SLOTS      = 32;

	typedef struct {
		dqe_pkg::cmd_item_t item;
		bit                 typed;
		dqe_pkg::res_item_t res;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cmd_valid;
	logic               cmd_ready;
	dqe_pkg::cmd_item_t cmd_item;
	logic               res_valid;
	logic               res_ready;
	dqe_pkg::res_item_t res_item;

	// shadow copy of the queue
	logic signed [dqe_pkg::WORD_W-1:0] dq_store [dqe_pkg::DEPTH];
	int dq_head  = 0;
	int dq_count = 0;

	// expected results in arrival order, written and read by running totals
	dqe_pkg::res_item_t exp_ring [EXP_SLOTS];
	int                 exp_wr = 0;
	int                 exp_rd = 0;
	dir_row_t           dir_rows [ROW_SLOTS];
	int                 dir_row_cnt    = 0;
	int                 mismatch_count = 0;
	int                 stall_cycles   = 0;
	int                 idle_pct       = 20;
	bit                 calm           = 1'b0;
	bit                 rx_hold_req    = 1'b0;

	double_ended_queue_engine_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	// clock, period 2
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// physical slot of a logical position in the shadow queue
	function automatic int queue_slot(int pos);
		return (dq_head + pos) % dqe_pkg::DEPTH;
	endfunction

	// apply one command to the shadow queue and return the result item
	function automatic dqe_pkg::res_item_t apply_command(dqe_pkg::cmd_item_t c);
		dqe_pkg::res_item_t                r;
		logic signed [dqe_pkg::WORD_W-1:0] t;
		int                                i;
		int                                j;
		r.status = dqe_pkg::ST_DONE;
		case (c.cmd)
			dqe_pkg::CMD_PUSH_FRONT: begin
				if (dq_count >= dqe_pkg::DEPTH) begin
					r.status = dqe_pkg::ST_FULL;
				end else begin
					dq_head = (dq_head == 0) ? dqe_pkg::DEPTH - 1 : dq_head - 1;
					dq_store[dq_head] = c.value;
					dq_count++;
				end
			end
			dqe_pkg::CMD_PUSH_BACK: begin
				if (dq_count >= dqe_pkg::DEPTH) begin
					r.status = dqe_pkg::ST_FULL;
				end else begin
					dq_store[queue_slot(dq_count)] = c.value;
					dq_count++;
				end
			end
			dqe_pkg::CMD_POP_FRONT: begin
				if (dq_count == 0) begin
					r.status = dqe_pkg::ST_EMPTY;
				end else begin
					dq_head = queue_slot(1);
					dq_count--;
				end
			end
			dqe_pkg::CMD_POP_BACK: begin
				if (dq_count == 0) begin
					r.status = dqe_pkg::ST_EMPTY;
				end else begin
					dq_count--;
				end
			end
			dqe_pkg::CMD_CLEAR: begin
				dq_count = 0;
				dq_head  = 0;
			end
			dqe_pkg::CMD_REVERSE: begin
				i = 0;
				j = dq_count - 1;
				while (i < j) begin
					t = dq_store[queue_slot(i)];
					dq_store[queue_slot(i)] = dq_store[queue_slot(j)];
					dq_store[queue_slot(j)] = t;
					i++;
					j--;
				end
			end
			dqe_pkg::CMD_SORT: begin
				// ascending signed order, insertion in place
				for (i = 1; i < dq_count; i++) begin
					t = dq_store[queue_slot(i)];
					j = i;
					while (j > 0 && t < dq_store[queue_slot(j - 1)]) begin
						dq_store[queue_slot(j)] = dq_store[queue_slot(j - 1)];
						j--;
					end
					dq_store[queue_slot(j)] = t;
				end
			end
			default: ;
		endcase
		// both ends read as all ones when empty
		if (dq_count == 0) begin
			r.front_value = dqe_pkg::EMPTY_WORD;
			r.back_value  = dqe_pkg::EMPTY_WORD;
		end else begin
			r.front_value = dq_store[dq_head];
			r.back_value  = dq_store[queue_slot(dq_count - 1)];
		end
		r.count = dqe_pkg::COUNT_W'(dq_count);
		return r;
	endfunction

	function automatic dqe_pkg::cmd_item_t make_cmd(logic [2:0] cmd,
			logic signed [dqe_pkg::WORD_W-1:0] value = '0);
		dqe_pkg::cmd_item_t c;
		c.cmd   = cmd;
		c.value = value;
		return c;
	endfunction

	task automatic add_row(logic [2:0] cmd, logic signed [dqe_pkg::WORD_W-1:0] value,
			bit typed, logic signed [dqe_pkg::WORD_W-1:0] front,
			logic signed [dqe_pkg::WORD_W-1:0] back, int cnt, logic [1:0] st);
		dir_row_t row;
		row.item                = make_cmd(cmd, value);
		row.typed               = typed;
		row.res.front_value     = front;
		row.res.back_value      = back;
		row.res.count           = dqe_pkg::COUNT_W'(cnt);
		row.res.status          = st;
		dir_rows[dir_row_cnt]   = row;
		dir_row_cnt++;
	endtask

	// offer one item, wait for accept, record its expected result
	task automatic send_item(dqe_pkg::cmd_item_t c, bit typed = 1'b0,
			dqe_pkg::res_item_t typed_res = '0);
		dqe_pkg::res_item_t predicted;
		int                 gap;
		if (!calm && $urandom_range(1, 100) <= idle_pct) begin
			cmd_valid <= 1'b0;
			gap = $urandom_range(1, 10);
			repeat (gap) @(negedge clk);
		end
		cmd_item  <= c;
		cmd_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!cmd_ready);
		predicted = apply_command(c);
		exp_ring[exp_wr % EXP_SLOTS] = typed ? typed_res : predicted;
		exp_wr++;
		@(negedge clk);
	endtask

	// stop offering until every outstanding result has come back
	task automatic drain_results();
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (exp_wr != exp_rd) @(negedge clk);
	endtask

	task automatic check_field(string name, logic [dqe_pkg::WORD_W-1:0] want,
			logic [dqe_pkg::WORD_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	// result checker
	always @(posedge clk) begin : res_check
		dqe_pkg::res_item_t want;
		if (arst_n && res_valid && res_ready) begin
			if (exp_wr == exp_rd) begin
				$display("%0t: unexpected result item, expected none, actual %p", $time,
					res_item);
				mismatch_count++;
			end else begin
				want = exp_ring[exp_rd % EXP_SLOTS];
				exp_rd++;
				check_field("front_value", want.front_value, res_item.front_value);
				check_field("back_value", want.back_value, res_item.back_value);
				check_field("count", 32'(want.count), 32'(res_item.count));
				check_field("status", 32'(want.status), 32'(res_item.status));
			end
		end
	end

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result receiver with random stalls and one long hold-off
	initial begin : res_sink
		int gap;
		res_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				res_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
				res_ready <= 1'b1;
			end else if (!calm && $urandom_range(1, 100) <= idle_pct) begin
				res_ready <= 1'b0;
				gap = $urandom_range(1, 10);
				repeat (gap) @(negedge clk);
				res_ready <= 1'b1;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	// command stimulus
	initial begin : stimulus
		dqe_pkg::cmd_item_t c;
		int                 r;
		int                 k;
		int                 n;
		int                 push_lim;
		bit                 grow;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd_item  = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table: cmd, value, typed, front, back, count, status
		add_row(dqe_pkg::CMD_POP_FRONT,  0,  1, NO_END, NO_END, 0, dqe_pkg::ST_EMPTY);
		add_row(dqe_pkg::CMD_POP_BACK,   -1, 1, NO_END, NO_END, 0, dqe_pkg::ST_EMPTY);
		add_row(CMD_UNUSED,        MAX_WORD, 1, NO_END, NO_END, 0, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_REVERSE,    0,  1, NO_END, NO_END, 0, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_SORT,       0,  1, NO_END, NO_END, 0, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_CLEAR,      0,  1, NO_END, NO_END, 0, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_PUSH_BACK,  MAX_WORD, 1, MAX_WORD, MAX_WORD, 1, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_REVERSE,    0,  1, MAX_WORD, MAX_WORD, 1, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_SORT,       0,  1, MAX_WORD, MAX_WORD, 1, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_PUSH_FRONT, MIN_WORD, 1, MIN_WORD, MAX_WORD, 2, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_PUSH_BACK,  0,  1, MIN_WORD, 0,        3, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_PUSH_FRONT, -1, 1, -1,       0,        4, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_PUSH_BACK,  1,  1, -1,       1,        5, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_REVERSE,    0,  1, 1,        -1,       5, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_SORT,       0,  1, MIN_WORD, MAX_WORD, 5, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_POP_FRONT,  0,  1, -1,       MAX_WORD, 4, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_POP_BACK,   0,  1, -1,       1,        3, dqe_pkg::ST_DONE);
		add_row(CMD_UNUSED,    32'h5A5A5A5A, 1, -1,       1,        3, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_PUSH_BACK,  1,  0, 0,        0,        0, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_PUSH_FRONT, 1,  0, 0,        0,        0, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_SORT,       0,  0, 0,        0,        0, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_REVERSE,    0,  0, 0,        0,        0, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_CLEAR,      0,  1, NO_END,   NO_END,   0, dqe_pkg::ST_DONE);
		add_row(dqe_pkg::CMD_POP_BACK,   0,  1, NO_END,   NO_END,   0, dqe_pkg::ST_EMPTY);
		add_row(dqe_pkg::CMD_PUSH_FRONT, 32'h2468ACE0, 0, 0, 0,     0, dqe_pkg::ST_DONE);
		for (n = 0; n < dir_row_cnt; n++) begin
			send_item(dir_rows[n].item, dir_rows[n].typed, dir_rows[n].res);
		end
		drain_results();

		// random traffic at small depths
		grow = 1'b1;
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 40 == 0) begin
				grow = 1'($urandom_range(0, 1));
				case ($urandom_range(0, 3))
					0: idle_pct = 0;
					1: idle_pct = 5;
					2: idle_pct = 20;
					default: idle_pct = 40;
				endcase
			end
			if (dq_count >= DEPTH_CAP) begin
				grow = 1'b0;
			end
			calm = (k >= RANDOM_ITEMS - CALM_ITEMS);
			// receiver holds off while commands keep coming
			if (k == HOLD_AT_ITEM) begin
				rx_hold_req = 1'b1;
			end
			if (k == RANDOM_ITEMS / 2) begin
				drain_results();
			end
			// small values give ties in sort, extremes hit the sign boundary
			case ($urandom_range(0, 3))
				0: c.value = $urandom_range(0, 6) - 3;
				1: begin
					case ($urandom_range(0, 3))
						0: c.value = MIN_WORD;
						1: c.value = MAX_WORD;
						2: c.value = 0;
						default: c.value = dqe_pkg::EMPTY_WORD;
					endcase
				end
				default: c.value = $urandom;
			endcase
			r = $urandom_range(0, 99);
			push_lim = grow ? 55 : 25;
			if (r < push_lim) begin
				c.cmd = r[0] ? dqe_pkg::CMD_PUSH_FRONT : dqe_pkg::CMD_PUSH_BACK;
			end else if (r < 86) begin
				c.cmd = r[0] ? dqe_pkg::CMD_POP_FRONT : dqe_pkg::CMD_POP_BACK;
			end else if (r < 89) begin
				c.cmd = dqe_pkg::CMD_CLEAR;
			end else if (r < 94) begin
				c.cmd = dqe_pkg::CMD_REVERSE;
			end else if (r < 98) begin
				c.cmd = dqe_pkg::CMD_SORT;
			end else begin
				c.cmd = CMD_UNUSED;
			end
			send_item(c);
		end

		// wait out the last results, then a short tail for strays
		cmd_valid <= 1'b0;
		while (exp_wr != exp_rd) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
